// ----- design/kmc_pkg.sv -----
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants of the two-dimensional k-means cluster engine.
// ----------------------------------------------------------------------------
package kmc_pkg;

  localparam int COORD_W      = 16;
  localparam int NUM_CLUSTERS = 4;
  localparam int IDX_W        = 2;
  localparam int NCNT_W       = $clog2(NUM_CLUSTERS + 1);
  localparam int DIST_W       = 2 * COORD_W + 1;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CIU_W        = 3;

  localparam logic [1:0] REQ_POINT  = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_LOAD   = 2'd2;

  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_CENTRE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 2'd1;

  localparam logic [CIU_W-1:0]   CLUSTERS_RESET = 3'd4;
  localparam logic [COORD_W-1:0] SEED_RESET     = 16'd44257;
  localparam logic [15:0]        LFSR_TAPS      = 16'hB400;
  localparam logic [15:0]        SCALE_NUM      = 16'd51200;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PT_WAIT,
    ST_PT_EMIT,
    ST_UP_START,
    ST_RS_STEP,
    ST_RS_SCALE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_UP_EMIT
  } st_t;

  // Token that walks the cell chain for one point.
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               have;
    logic [DIST_W-1:0]  best_d;
    logic [IDX_W-1:0]   best_idx;
    logic               best_full;
  } pt_tok_t;

  // Broadcast control from the sequencer to all cells.
  typedef struct packed {
    logic               load_en;
    logic               acc_en;
    logic               clr;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } cell_ctl_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] r;
    r = v >> 1;
    if (v[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

endpackage

// ----- design/kmeans_2d_cluster_engine.sv -----
// ----------------------------------------------------------------------------
// kmeans_2d_cluster_engine
// Two-dimensional k-means in unsigned Q7.9 with a chain of centroid cells.
// ----------------------------------------------------------------------------
// One word is processed at a time. A point walks the chain of four centroid
// cells, two register stages per cell, before its assignment word is
// presented. A load word is written straight into its cell. An end-of-pass
// word visits the active clusters in order: an occupied one needs two runs
// of the bit-serial divider (SUM_W is 16 + log2(MAX_POINTS)), and an empty
// one two LFSR draws; each emitted centroid then waits for the output
// register to be free.
module kmeans_2d_cluster_engine import kmc_pkg::*; #(
  parameter int MAX_POINTS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_req_type,
  input  logic [COORD_W-1:0]    in_coord_x,
  input  logic [COORD_W-1:0]    in_coord_y,
  input  logic [IDX_W-1:0]      in_target_cluster,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_result_kind,
  output logic [IDX_W-1:0]      out_cluster_index,
  output logic [COORD_W-1:0]    out_centroid_x,
  output logic [COORD_W-1:0]    out_centroid_y,
  output logic                  out_reseeded,
  output logic                  out_dropped,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = COORD_W + $clog2(MAX_POINTS);

  st_t                state_r, state_nxt;
  logic [CIU_W-1:0]   clusters_r;
  logic [15:0]        lfsr_r;
  logic [IDX_W-1:0]   k_r;
  logic               ph_r;
  logic [COORD_W-1:0] res_x_r, res_y_r, pt_x_r, pt_y_r;
  logic               empty_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic               drop_r;
  logic [31:0]        prod_r;
  logic [32:0]        scale_sum;
  logic [COORD_W-1:0] scaled;

  logic               out_valid_r, out_kind_r, out_res_r, out_drop_r, out_last_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [COORD_W-1:0] out_cx_r, out_cy_r;

  pt_tok_t            tok [NUM_CLUSTERS+1];
  cell_ctl_t          ctl;
  logic [SUM_W-1:0]   sx [NUM_CLUSTERS];
  logic [SUM_W-1:0]   sy [NUM_CLUSTERS];
  logic [CNT_W-1:0]   cnt [NUM_CLUSTERS];

  logic               in_fire, cfg_fire, out_free;
  logic [NCNT_W-1:0]  n_eff;
  logic [IDX_W-1:0]   k_last;
  logic               div_start, div_done;
  logic [COORD_W-1:0] div_q;
  logic [15:0]        lfsr_nxt;

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_ready;

  // Zero active clusters behaves as one, too many as all of them.
  always_comb begin
    if (clusters_r == '0) begin
      n_eff = NCNT_W'(1);
    end else if (clusters_r > CIU_W'(NUM_CLUSTERS)) begin
      n_eff = NCNT_W'(NUM_CLUSTERS);
    end else begin
      n_eff = NCNT_W'(clusters_r);
    end
  end
  assign k_last = IDX_W'(n_eff - NCNT_W'(1));

  // Point token entering the chain.
  always_comb begin
    tok[0]           = '0;
    tok[0].valid     = in_fire && (in_req_type == REQ_POINT);
    tok[0].x         = in_coord_x;
    tok[0].y         = in_coord_y;
  end

  for (genvar g = 0; g < NUM_CLUSTERS; g++) begin : g_cell
    kmc_cell #(
      .MAX_POINTS(MAX_POINTS),
      .CELL_ID   (g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .active (NCNT_W'(g) < n_eff),
      .tok_i  (tok[g]),
      .ctl_i  (ctl),
      .tok_o  (tok[g+1]),
      .sum_x_o(sx[g]),
      .sum_y_o(sy[g]),
      .count_o(cnt[g])
    );
  end

  kmc_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(ph_r ? sy[k_r] : sx[k_r]),
    .divisor (cnt[k_r]),
    .done    (div_done),
    .quotient(div_q)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req_type)
            REQ_POINT:  state_nxt = ST_PT_WAIT;
            REQ_UPDATE: state_nxt = ST_UP_START;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PT_WAIT: begin
        if (tok[NUM_CLUSTERS].valid) begin
          state_nxt = ST_PT_EMIT;
        end
      end
      ST_PT_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_UP_START: begin
        state_nxt = (cnt[k_r] == '0) ? ST_RS_STEP : ST_DIV_GO;
      end
      ST_RS_STEP:  state_nxt = ST_RS_SCALE;
      ST_RS_SCALE: state_nxt = ph_r ? ST_UP_EMIT : ST_RS_STEP;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = ph_r ? ST_UP_EMIT : ST_DIV_GO;
        end
      end
      ST_UP_EMIT: begin
        if (out_free) begin
          state_nxt = (k_r == k_last) ? ST_IDLE : ST_UP_START;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    div_start = (state_r == ST_DIV_GO);
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        ctl.load_en = in_valid && (in_req_type == REQ_LOAD);
        ctl.idx     = in_target_cluster;
        ctl.x       = in_coord_x;
        ctl.y       = in_coord_y;
      end
      ST_PT_EMIT: begin
        ctl.acc_en = out_free && !drop_r;
        ctl.idx    = best_idx_r;
        ctl.x      = pt_x_r;
        ctl.y      = pt_y_r;
      end
      ST_UP_EMIT: begin
        ctl.load_en = out_free;
        ctl.clr     = out_free && (k_r == k_last);
        ctl.idx     = k_r;
        ctl.x       = res_x_r;
        ctl.y       = res_y_r;
      end
      default: ctl = '0;
    endcase
  end

  assign lfsr_nxt  = lfsr_step(lfsr_r);
  // floor(p / 65535) for p below 51200 * 65536.
  assign scale_sum = {1'b0, prod_r} + {17'b0, prod_r[31:16]} + 33'd1;
  assign scaled    = scale_sum[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      clusters_r <= CLUSTERS_RESET;
      lfsr_r     <= SEED_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire && (cfg_index == CFG_CLUSTERS)) begin
        clusters_r <= cfg_data[CIU_W-1:0];
      end
      if (cfg_fire && (cfg_index == CFG_SEED)) begin
        lfsr_r <= (cfg_data == '0) ? 16'd1 : cfg_data;
      end else if (state_r == ST_RS_STEP) begin
        lfsr_r <= lfsr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pt_x_r <= in_coord_x;
      pt_y_r <= in_coord_y;
      k_r    <= '0;
    end
    if (tok[NUM_CLUSTERS].valid) begin
      best_idx_r <= tok[NUM_CLUSTERS].best_idx;
      drop_r     <= tok[NUM_CLUSTERS].best_full;
    end
    if (state_r == ST_UP_START) begin
      ph_r    <= 1'b0;
      empty_r <= (cnt[k_r] == '0);
    end
    if (state_r == ST_RS_STEP) begin
      prod_r <= lfsr_nxt * SCALE_NUM;
    end
    if (state_r == ST_RS_SCALE) begin
      if (ph_r) begin
        res_y_r <= scaled;
      end else begin
        res_x_r <= scaled;
      end
      ph_r <= 1'b1;
    end
    if ((state_r == ST_DIV_WAIT) && div_done) begin
      if (ph_r) begin
        res_y_r <= div_q;
      end else begin
        res_x_r <= div_q;
      end
      ph_r <= 1'b1;
    end
    if ((state_r == ST_UP_EMIT) && out_free) begin
      k_r <= k_r + IDX_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_PT_EMIT || state_r == ST_UP_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if ((state_r == ST_PT_EMIT) && out_free) begin
      out_kind_r <= KIND_POINT;
      out_idx_r  <= best_idx_r;
      out_cx_r   <= '0;
      out_cy_r   <= '0;
      out_res_r  <= 1'b0;
      out_drop_r <= drop_r;
      out_last_r <= 1'b1;
    end else if ((state_r == ST_UP_EMIT) && out_free) begin
      out_kind_r <= KIND_CENTRE;
      out_idx_r  <= k_r;
      out_cx_r   <= res_x_r;
      out_cy_r   <= res_y_r;
      out_res_r  <= empty_r;
      out_drop_r <= 1'b0;
      out_last_r <= (k_r == k_last);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_cluster_index = out_idx_r;
  assign out_centroid_x    = out_cx_r;
  assign out_centroid_y    = out_cy_r;
  assign out_reseeded      = out_res_r;
  assign out_dropped       = out_drop_r;
  assign out_last          = out_last_r;

endmodule

// ----- design/kmc_cell.sv -----
// ----------------------------------------------------------------------------
// kmc_cell
// One centroid slot: holds the centroid, its sums and member count, and
// compares a passing point token against its centroid.
// ----------------------------------------------------------------------------
module kmc_cell import kmc_pkg::*; #(
  parameter int MAX_POINTS = 256,
  parameter int CELL_ID    = 0,
  localparam int CNT_W     = $clog2(MAX_POINTS + 1),
  localparam int SUM_W     = COORD_W + $clog2(MAX_POINTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             active,
  input  pt_tok_t          tok_i,
  input  cell_ctl_t        ctl_i,
  output pt_tok_t          tok_o,
  output logic [SUM_W-1:0] sum_x_o,
  output logic [SUM_W-1:0] sum_y_o,
  output logic [CNT_W-1:0] count_o
);

  logic [COORD_W-1:0]   cx_r, cy_r;
  logic [SUM_W-1:0]     sx_r, sy_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 a_vld_r;
  pt_tok_t              a_tok_r;
  logic [2*COORD_W-1:0] a_dx2_r, a_dy2_r;
  pt_tok_t              tok_r, tok_nxt;
  logic [COORD_W-1:0]   dx, dy;
  logic [DIST_W-1:0]    dist_sum;
  logic                 take;
  logic                 sel;

  assign sel = (ctl_i.idx == IDX_W'(CELL_ID));
  assign dx  = (tok_i.x >= cx_r) ? tok_i.x - cx_r : cx_r - tok_i.x;
  assign dy  = (tok_i.y >= cy_r) ? tok_i.y - cy_r : cy_r - tok_i.y;

  // First stage: squares of the distances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= tok_i.valid;
    end
    a_tok_r <= tok_i;
    a_dx2_r <= dx * dx;
    a_dy2_r <= dy * dy;
  end

  // Second stage: sum and compare; the first active cell always takes the token, a later one only if strictly closer.
  assign dist_sum = {1'b0, a_dx2_r} + {1'b0, a_dy2_r};
  assign take     = active && (!a_tok_r.have || (dist_sum < a_tok_r.best_d));

  always_comb begin
    tok_nxt       = a_tok_r;
    tok_nxt.valid = a_vld_r;
    if (take) begin
      tok_nxt.have      = 1'b1;
      tok_nxt.best_d    = dist_sum;
      tok_nxt.best_idx  = IDX_W'(CELL_ID);
      tok_nxt.best_full = (cnt_r >= CNT_W'(MAX_POINTS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.x         <= tok_nxt.x;
    tok_r.y         <= tok_nxt.y;
    tok_r.have      <= tok_nxt.have;
    tok_r.best_d    <= tok_nxt.best_d;
    tok_r.best_idx  <= tok_nxt.best_idx;
    tok_r.best_full <= tok_nxt.best_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (ctl_i.load_en && sel) begin
        cx_r <= ctl_i.x;
        cy_r <= ctl_i.y;
      end
      if (ctl_i.clr) begin
        sx_r  <= '0;
        sy_r  <= '0;
        cnt_r <= '0;
      end else if (ctl_i.acc_en && sel) begin
        sx_r  <= sx_r + SUM_W'(ctl_i.x);
        sy_r  <= sy_r + SUM_W'(ctl_i.y);
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign tok_o   = tok_r;
  assign sum_x_o = sx_r;
  assign sum_y_o = sy_r;
  assign count_o = cnt_r;

endmodule

// ----- design/kmc_div.sv -----
// ----------------------------------------------------------------------------
// kmc_div
// Restoring divider, one quotient bit per cycle, for the centroid means.
// ----------------------------------------------------------------------------
module kmc_div import kmc_pkg::*; #(
  parameter int SUM_W = 24,
  parameter int CNT_W = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [CNT_W-1:0]   divisor,
  output logic               done,
  output logic [COORD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  q_r;
  logic [CNT_W:0]    rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic [CNT_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem_r[CNT_W-1:0], q_r[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[SUM_W-2:0], ge};
      rem_r <= ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
    end
  end

  assign done     = done_r;
  assign quotient = q_r[COORD_W-1:0];

endmodule

// ----- design/kmc_checker.sv -----
// ----------------------------------------------------------------------------
// kmc_checker
// Port-level checks of the k-means cluster engine, bound to the top level.
// ----------------------------------------------------------------------------
module kmc_checker import kmc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [1:0]            in_req_type,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_result_kind,
  input logic [COORD_W-1:0]    out_centroid_x,
  input logic [COORD_W-1:0]    out_centroid_y,
  input logic                  out_reseeded,
  input logic                  out_dropped,
  input logic                  out_last
);

  // A waiting result word is held.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A point word is a single, final result with no centroid.
  a_point_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_POINT) |->
      out_last && !out_reseeded && (out_centroid_x == '0) && (out_centroid_y == '0))
    else $error("malformed point result word");

  // Updated centroids never carry the dropped flag.
  a_centre_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_CENTRE) |-> !out_dropped)
    else $error("dropped flag on centroid word");

  // An accepted point keeps the engine busy in the next cycle.
  a_point_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_POINT) |=> !in_ready)
    else $error("input accepted while a point is in flight");

endmodule

bind kmeans_2d_cluster_engine kmc_checker u_kmc_checker (.*);
